// ----- rtl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared codes and types of the double-ended queue: operation and status
// codes, the per-cell control word and the sequencer states.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned STATUS_W = 2;

    // Operation codes carried in the kind field
    localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LIST       = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // What every cell does on each clock edge
    typedef enum logic [2:0] {
        CELL_HOLD,       // keep the held value
        CELL_SHIFT_IN,   // take the left neighbour (front push)
        CELL_SHIFT_OUT,  // take the right neighbour (front pop)
        CELL_WRITE,      // the cell at the rear takes the pushed value
        CELL_ROTATE      // take the right neighbour, the tail takes the front
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     at_rear;  // first free position
        logic     at_tail;  // last held position
    } cell_ctrl_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LIST
    } deq_state_t;

endpackage

// ----- rtl/deq_stream_if.sv -----
// ----------------------------------------------------------------------------
// deq_req_if / deq_rsp_if
// Valid/ready channels of the double-ended queue: operation requests in,
// results out. A transfer happens on a rising edge with valid and ready high.
// ----------------------------------------------------------------------------
interface deq_req_if;
    import deq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface deq_rsp_if;
    import deq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value_out;
    logic [STATUS_W-1:0]      status;
    logic                     last;

    modport source (output valid, output value_out, output status, output last,
                    input ready);
    modport sink   (input valid, input value_out, input status, input last,
                    output ready);
endinterface

// ----- rtl/deq_cell.sv -----
// ----------------------------------------------------------------------------
// deq_cell
// One position of the queue. Holds one value and, under the broadcast
// control word, keeps it, takes a neighbour's value or takes the pushed value.
// ----------------------------------------------------------------------------
module deq_cell
    import deq_pkg::*;
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic signed [DATA_W-1:0] push_value,
    input  logic signed [DATA_W-1:0] left_value,
    input  logic signed [DATA_W-1:0] right_value,
    input  logic signed [DATA_W-1:0] head_value,
    output logic signed [DATA_W-1:0] value
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.op)
            CELL_HOLD:      value_next = value_reg;
            CELL_SHIFT_IN:  value_next = left_value;
            CELL_SHIFT_OUT: value_next = right_value;
            CELL_WRITE:
            begin
                if (ctrl.at_rear)
                begin
                    value_next = push_value;
                end
            end
            CELL_ROTATE:
            begin
                // the tail closes the ring back to the front
                value_next = ctrl.at_tail ? head_value : right_value;
            end
            default:        value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- rtl/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// A push or pop result is registered and shown in the cycle after the request transfer.
// Throughput: one push or pop per cycle while the result slot is free; a
// listing emits one entry per cycle while the result slot is free, as the cell row
// rotates, and holds off further requests until its last entry is loaded.
// Reset: asynchronous, empties the queue and the output register; cell
// contents are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    deq_req_if.sink       req,
    deq_rsp_if.source     rsp
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);
    localparam logic [CW-1:0] COUNT_ONE  = CW'(1);

    deq_state_t state_reg;
    deq_state_t state_next;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] remain_reg;
    logic [CW-1:0] remain_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DATA_W-1:0] value_out_reg;
    logic signed [DATA_W-1:0] value_out_next;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    logic                     last_reg;
    logic                     last_next;

    logic                     slot_free;
    logic                     accept;
    logic                     emit;
    cell_op_t                 op;
    logic signed [DATA_W-1:0] tail_value;

    cell_ctrl_t               cell_ctrl  [DEPTH];
    logic signed [DATA_W-1:0] cell_value [DEPTH];

    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && slot_free;
    assign accept    = req.valid && req.ready;

    // ------------------------------------------------------------------
    // Cell row, front at position 0
    // ------------------------------------------------------------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CW-1:0] POS      = CW'(i);
        localparam logic [CW-1:0] POS_NEXT = CW'(i + 1);

        logic signed [DATA_W-1:0] left_value;
        logic signed [DATA_W-1:0] right_value;

        assign cell_ctrl[i].op      = op;
        assign cell_ctrl[i].at_rear = (count_reg == POS);
        assign cell_ctrl[i].at_tail = (count_reg == POS_NEXT);

        if (i == 0)
        begin : g_first
            assign left_value = req.value;
        end
        else
        begin : g_inner_left
            assign left_value = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_value = cell_value[i];
        end
        else
        begin : g_inner_right
            assign right_value = cell_value[i+1];
        end

        deq_cell u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl[i]),
            .push_value  (req.value),
            .left_value  (left_value),
            .right_value (right_value),
            .head_value  (cell_value[0]),
            .value       (cell_value[i])
        );
    end

    // pick the held value at the tail for a rear pop
    always_comb
    begin
        tail_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_value = tail_value | (cell_value[i] & {DATA_W{cell_ctrl[i].at_tail}});
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.kind == KIND_LIST) && (count_reg > COUNT_ONE))
                begin
                    state_next = ST_LIST;
                end
            end
            ST_LIST:
            begin
                if (slot_free && (remain_reg == COUNT_ONE))
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        op             = CELL_HOLD;
        count_next     = count_reg;
        remain_next    = remain_reg;
        emit           = 1'b0;
        value_out_next = value_out_reg;
        status_next    = status_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    value_out_next = '0;
                    status_next    = STATUS_OK;
                    last_next      = 1'b1;
                    case (req.kind)
                        KIND_PUSH_REAR, KIND_PUSH_FRONT:
                        begin
                            emit = 1'b1;
                            if (count_reg == COUNT_FULL)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                op = (req.kind == KIND_PUSH_REAR) ? CELL_WRITE
                                                                  : CELL_SHIFT_IN;
                                count_next = count_reg + COUNT_ONE;
                            end
                        end
                        KIND_POP_FRONT, KIND_POP_REAR:
                        begin
                            emit = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                if (req.kind == KIND_POP_FRONT)
                                begin
                                    op             = CELL_SHIFT_OUT;
                                    value_out_next = cell_value[0];
                                end
                                else
                                begin
                                    value_out_next = tail_value;
                                end
                                count_next = count_reg - COUNT_ONE;
                            end
                        end
                        KIND_LIST:
                        begin
                            emit = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                // first entry goes out with the transfer itself
                                op             = CELL_ROTATE;
                                value_out_next = cell_value[0];
                                last_next      = (count_reg == COUNT_ONE);
                                remain_next    = count_reg - COUNT_ONE;
                            end
                        end
                        default:
                        begin
                            // unused codes: drop the request
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            ST_LIST:
            begin
                if (slot_free)
                begin
                    emit           = 1'b1;
                    op             = CELL_ROTATE;
                    value_out_next = cell_value[0];
                    status_next    = STATUS_OK;
                    last_next      = (remain_reg == COUNT_ONE);
                    remain_next    = remain_reg - COUNT_ONE;
                end
            end
            default:
            begin
                op = CELL_HOLD;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_out_reg <= value_out_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.value_out = value_out_reg;
    assign rsp.status    = status_reg;
    assign rsp.last      = last_reg;

endmodule

// ----- rtl/deq_checker.sv -----
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks of the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker
    import deq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    input  logic                     req_ready,
    input  logic [KIND_W-1:0]        req_kind,
    input  logic                     rsp_valid,
    input  logic                     rsp_ready,
    input  logic signed [DATA_W-1:0] rsp_value_out,
    input  logic [STATUS_W-1:0]      rsp_status,
    input  logic                     rsp_last
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_out)
                                    && $stable(rsp_status) && $stable(rsp_last))
        else $error("stalled result changed");

    // a request is only taken when its result has room
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> !rsp_valid || rsp_ready)
        else $error("request taken while result slot blocked");

    // every push or pop answers in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_kind == KIND_PUSH_REAR || req_kind == KIND_PUSH_FRONT
            || req_kind == KIND_POP_FRONT || req_kind == KIND_POP_REAR) |=> rsp_valid && rsp_last)
        else $error("push or pop gave no result");

    // an error or empty status is a lone, zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != STATUS_OK |-> rsp_last && rsp_value_out == '0
            && (rsp_status == STATUS_EMPTY || rsp_status == STATUS_FULL))
        else $error("malformed status result");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_kind      (req.kind),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_value_out (rsp.value_out),
    .rsp_status    (rsp.status),
    .rsp_last      (rsp.last)
);

// ----- dv/deq_scoreboard.sv -----
// ----------------------------------------------------------------------------
// deq_scoreboard
// Watches the request and result channels of the double-ended queue. It keeps
// its own ring of held values to work out the results of every operation,
// compares each result transfer with the oldest outstanding one, and reports
// the number of failures and of results still due.
// ----------------------------------------------------------------------------
module deq_scoreboard
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH = 32
)
(
    input  logic clk,
    input  logic rst_n,
    deq_req_if   req,
    deq_rsp_if   rsp,
    output int   fail_count,
    output int   pending,
    output int   result_count
);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [STATUS_W-1:0]      status;
        logic                     last;
    } deq_result_t;

    deq_result_t              due_results[$];
    logic signed [DATA_W-1:0] ring [DEPTH];
    int unsigned              front_pos;
    int unsigned              fill;

    function automatic void queue_result(input logic signed [DATA_W-1:0] v,
                                         input logic [STATUS_W-1:0] st,
                                         input logic lst);
        deq_result_t r;
        r.value  = v;
        r.status = st;
        r.last   = lst;
        due_results.push_back(r);
    endfunction

    // Work out what one accepted operation returns and update the held ring
    function automatic void predict_deque_op(input logic [KIND_W-1:0] kind,
                                             input logic signed [DATA_W-1:0] v);
        int unsigned i;
        case (kind)
            KIND_PUSH_REAR:
                if (fill >= DEPTH)
                    queue_result('0, STATUS_FULL, 1'b1);
                else
                begin
                    ring[(front_pos + fill) % DEPTH] = v;
                    fill++;
                    queue_result('0, STATUS_OK, 1'b1);
                end
            KIND_PUSH_FRONT:
                if (fill >= DEPTH)
                    queue_result('0, STATUS_FULL, 1'b1);
                else
                begin
                    front_pos = (front_pos + DEPTH - 1) % DEPTH;
                    ring[front_pos] = v;
                    fill++;
                    queue_result('0, STATUS_OK, 1'b1);
                end
            KIND_POP_FRONT:
                if (fill == 0)
                    queue_result('0, STATUS_EMPTY, 1'b1);
                else
                begin
                    queue_result(ring[front_pos], STATUS_OK, 1'b1);
                    front_pos = (front_pos + 1) % DEPTH;
                    fill--;
                end
            KIND_POP_REAR:
                if (fill == 0)
                    queue_result('0, STATUS_EMPTY, 1'b1);
                else
                begin
                    queue_result(ring[(front_pos + fill - 1) % DEPTH], STATUS_OK, 1'b1);
                    fill--;
                end
            KIND_LIST:
                if (fill == 0)
                    queue_result('0, STATUS_EMPTY, 1'b1);
                else
                    for (i = 0; i < fill; i++)
                        queue_result(ring[(front_pos + i) % DEPTH], STATUS_OK,
                                     (i + 1 == fill));
            default:
                ; // unused codes are dropped by the block
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        deq_result_t want;
        if (!rst_n)
        begin
            due_results.delete();
            front_pos    = 0;
            fill         = 0;
            fail_count   = 0;
            result_count = 0;
            pending      = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                result_count++;
                if (due_results.size() == 0)
                begin
                    $display("%0t: unexpected result value %0d status %0d last %0b",
                             $time, rsp.value_out, rsp.status, rsp.last);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (rsp.value_out !== want.value || rsp.status !== want.status ||
                        rsp.last !== want.last)
                    begin
                        $display("%0t: result mismatch, expected value %0d status %0d last %0b, got value %0d status %0d last %0b",
                                 $time, want.value, want.status, want.last,
                                 rsp.value_out, rsp.status, rsp.last);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
                predict_deque_op(req.kind, req.value);
            pending = due_results.size();
        end
    end

endmodule

// ----- dv/double_ended_queue_test.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_test
// Drives push, pop and listing operations into the double-ended queue, with
// a short directed opening and then bursts that fill, drain or mix, while
// both channels idle at random. A scoreboard beside the block checks every
// result; this module gives the verdict.
// ----------------------------------------------------------------------------
module double_ended_queue_test;
    import deq_pkg::*;

    localparam int unsigned DEPTH        = 32;
    localparam int          RANDOM_ITEMS = 260;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          MODE_FILL    = 0;
    localparam int          MODE_DRAIN   = 1;
    localparam int          MODE_MIXED   = 2;

    localparam logic [KIND_W-1:0] KIND_FIRST_UNUSED = 3'd5;
    localparam logic [KIND_W-1:0] KIND_LAST_CODE    = {KIND_W{1'b1}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sink_ready = 1'b0;
    logic steady = 1'b0;
    int   fail_count;
    int   pending;
    int   result_count;
    int   cycle_count;
    int   n_push, n_pop, n_list, n_ignored;

    deq_req_if req_ch();
    deq_rsp_if rsp_ch();

    assign rsp_ch.ready = sink_ready;

    double_ended_queue #(.DEPTH(DEPTH)) uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    deq_scoreboard #(.DEPTH(DEPTH)) chk
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
        sink_ready <= rst_n && (steady || $urandom_range(0, 99) >= 31);

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Offer one operation and hold it until the transfer
    task automatic send_op(input logic [KIND_W-1:0] k, input logic signed [DATA_W-1:0] v);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 31)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= k;
        req_ch.value <= v;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        case (k)
            KIND_PUSH_REAR, KIND_PUSH_FRONT: n_push++;
            KIND_POP_FRONT, KIND_POP_REAR:   n_pop++;
            KIND_LIST:                       n_list++;
            default:                         n_ignored++;
        endcase
    endtask

    initial
    begin
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
        int                       done;
        int                       burst_left;
        int                       mode;
        int                       pick;
        int                       push_pct;

        req_ch.valid = 1'b0;
        req_ch.kind  = KIND_PUSH_REAR;
        req_ch.value = '0;
        n_push = 0;
        n_pop = 0;
        n_list = 0;
        n_ignored = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Empty-deque errors, the unused codes, then pushes, listings and pops at both ends
        send_op(KIND_LIST, 32'sd7);
        send_op(KIND_POP_FRONT, -32'sd1);
        send_op(KIND_POP_REAR, 32'sd1);
        for (int k = KIND_FIRST_UNUSED; k <= KIND_LAST_CODE; k++)
            send_op(k[KIND_W-1:0], 32'sd3);
        send_op(KIND_PUSH_REAR, 32'h7FFF_FFFF);
        send_op(KIND_PUSH_FRONT, 32'h8000_0000);
        send_op(KIND_PUSH_REAR, 32'h0000_0000);
        send_op(KIND_PUSH_FRONT, 32'hFFFF_FFFF);
        send_op(KIND_LIST, '0);
        send_op(KIND_POP_REAR, '0);
        send_op(KIND_POP_FRONT, '0);
        send_op(KIND_PUSH_REAR, 32'h5555_5555);
        send_op(KIND_PUSH_FRONT, 32'hAAAA_AAAA);
        send_op(KIND_LIST, '0);
        send_op(KIND_POP_REAR, '0);
        send_op(KIND_POP_REAR, '0);
        send_op(KIND_POP_FRONT, '0);
        send_op(KIND_POP_FRONT, '0);
        send_op(KIND_POP_REAR, '0);

        // Bursts that lean towards filling or draining reach both bounds
        done = 0;
        burst_left = 0;
        mode = MODE_MIXED;
        while (done < RANDOM_ITEMS)
        begin
            if (burst_left == 0)
            begin
                mode = $urandom_range(MODE_FILL, MODE_MIXED);
                burst_left = $urandom_range(25, 50);
            end
            burst_left--;
            steady = (done >= 120 && done < 180);
            pick = $urandom_range(0, 99);
            if (pick < 3)
                kind = KIND_W'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_CODE));
            else if (pick < 13)
                kind = KIND_LIST;
            else
            begin
                push_pct = (mode == MODE_FILL) ? 80 : (mode == MODE_DRAIN) ? 20 : 50;
                if ($urandom_range(0, 99) < push_pct)
                    kind = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_REAR;
                else
                    kind = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_REAR;
            end
            if ($urandom_range(0, 9) == 0)
                case ($urandom_range(0, 3))
                    0:       value = 32'h7FFF_FFFF;
                    1:       value = 32'h8000_0000;
                    2:       value = '0;
                    default: value = '1;
                endcase
            else
                value = $urandom;
            send_op(kind, value);
            if (kind < KIND_FIRST_UNUSED)
                done++;
        end
        steady = 1'b0;

        @(negedge clk);
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (8) @(negedge clk);

        $display("Ran %0d pushes, %0d pops, %0d listings and %0d unused codes",
                 n_push, n_pop, n_list, n_ignored);
        $display("Checked %0d results with %0d failures", result_count, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
